>>> rtl/lccp_pkg.sv
// Shared types and constants for the LED color command parser.
`default_nettype none

package lccp_pkg;

    // Default table capacity and depth of the front-to-back queue.
    localparam int DEF_MAX_COLORS = 64;
    localparam int QUEUE_DEPTH    = 4;

    // Command codes carried in the first byte of a message.
    localparam logic [7:0] CMD_CLEAR  = 8'd0;
    localparam logic [7:0] CMD_LIST   = 8'd1;
    localparam logic [7:0] CMD_ADD    = 8'd2;
    localparam logic [7:0] CMD_SINGLE = 8'd3;

    // Stored mode values.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_LIST   = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    // Position inside a message: what the next byte means.
    typedef enum logic [1:0] {
        POS_CMD    = 2'd0,
        POS_BRIGHT = 2'd1,
        POS_HIGH   = 2'd2,
        POS_LOW    = 2'd3
    } t_byte_pos;

    // Operations handed from the parser to the executor.
    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_SET    = 3'd2,
        OP_APPEND = 3'd3,
        OP_READ   = 3'd4
    } t_op_kind;

    // One queued operation.
    typedef struct packed {
        t_op_kind    kind;
        logic        start;      // Message opens: drop the overflow flag first.
        logic        last;       // Message closes: report a result afterwards.
        logic        status;     // Accept status reported on the last byte.
        logic [1:0]  mode;
        logic [7:0]  brightness;
        logic [15:0] color;
        logic [7:0]  index;
    } t_op_entry;

endpackage

`default_nettype wire

>>> rtl/led_color_command_parser.sv
// Top level of the LED color command parser.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     action, byte, first, last, read index
//  output    out        o_out_valid / i_out_stall   status, overflow, color, count, mode,
//                                                   brightness
//
// One transaction a cycle is taken at the input while the queue has room; each passes the
// parser, a four-entry queue and the executor, which handles one operation a cycle unless
// its result waits on a stalled output; results are valid once in the output register.
// Reset is synchronous and clears the parser, the queue and the stored state; the color
// table is not cleared, since only entries below the count are ever read.
// The input stalls only while the queue is full, which happens when the output is stalled.
`default_nettype none

module led_color_command_parser
    import lccp_pkg::*;
#(
    parameter int MAX_COLORS = DEF_MAX_COLORS,
    parameter int CW         = $clog2(MAX_COLORS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_action,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_first_byte,
    input  wire logic          i_last_byte,
    input  wire logic [7:0]    i_read_index,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_status,
    output logic               o_overflowed,
    output logic [15:0]        o_color_value,
    output logic [CW-1:0]      o_color_count,
    output logic [1:0]         o_current_mode,
    output logic [7:0]         o_current_brightness
);

    t_op_entry front_op;
    t_op_entry head_op;
    logic      accept;
    logic      q_full;
    logic      q_not_empty;
    logic      pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    lccp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_read_index (i_read_index),
        .o_op         (front_op)
    );

    lccp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_entry     (front_op),
        .i_pop       (pop),
        .o_head      (head_op),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    lccp_back #(
        .MAX_COLORS (MAX_COLORS),
        .CW         (CW)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_op                 (head_op),
        .i_op_valid           (q_not_empty),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_overflowed         (o_overflowed),
        .o_color_value        (o_color_value),
        .o_color_count        (o_color_count),
        .o_current_mode       (o_current_mode),
        .o_current_brightness (o_current_brightness)
    );

endmodule

`default_nettype wire

>>> rtl/lccp_front.sv
// Front end: parses message bytes and turns them into queued operations.
`default_nettype none

module lccp_front
    import lccp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_action,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [7:0] i_read_index,
    output t_op_entry       o_op
);

    t_byte_pos   r_pos, n_pos;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_bright, n_bright;
    logic [7:0]  r_high, n_high;
    logic        r_committed, n_committed;
    logic        r_rejected, n_rejected;
    logic [1:0]  r_mode, n_mode;
    logic        start;
    logic        list_cmd;

    // Classify the byte against the message state and build the operation.
    always_comb begin
        n_pos       = r_pos;
        n_cmd       = r_cmd;
        n_bright    = r_bright;
        n_high      = r_high;
        n_committed = r_committed;
        n_rejected  = r_rejected;
        n_mode      = r_mode;
        start       = 1'b0;
        list_cmd    = (r_cmd == CMD_LIST) || (r_cmd == CMD_ADD);

        o_op            = '0;
        o_op.kind       = OP_NOP;
        o_op.index      = i_read_index;
        o_op.brightness = r_bright;
        o_op.mode       = r_cmd[1:0];
        o_op.color      = {r_high, i_byte_value};

        if (i_action) begin
            o_op.kind = OP_READ;
        end else begin
            start = i_first_byte || (r_pos == POS_CMD && !r_committed && !r_rejected);
            if (start) begin
                // A new message: hold the command, a clear takes effect at once.
                n_cmd       = i_byte_value;
                n_bright    = '0;
                n_high      = '0;
                n_rejected  = 1'b0;
                n_committed = (i_byte_value == CMD_CLEAR);
                n_pos       = POS_BRIGHT;
                if (i_byte_value == CMD_CLEAR) begin
                    o_op.kind = OP_CLEAR;
                    n_mode    = MODE_OFF;
                end
            end else if (r_committed) begin
                // Committed list messages append further byte pairs.
                if (list_cmd) begin
                    if (r_pos == POS_HIGH) begin
                        n_high = i_byte_value;
                        n_pos  = POS_LOW;
                    end else begin
                        o_op.kind = OP_APPEND;
                        n_pos     = POS_HIGH;
                    end
                end
            end else if (!r_rejected) begin
                unique case (r_pos)
                    POS_CMD: begin
                    end
                    POS_BRIGHT: begin
                        n_bright = i_byte_value;
                        n_pos    = POS_HIGH;
                    end
                    POS_HIGH: begin
                        n_high = i_byte_value;
                        n_pos  = POS_LOW;
                    end
                    POS_LOW: begin
                        if (r_cmd == CMD_LIST || r_cmd == CMD_SINGLE) begin
                            o_op.kind   = OP_SET;
                            n_mode      = r_cmd[1:0];
                            n_committed = 1'b1;
                            n_pos       = POS_HIGH;
                        end else if (r_cmd == CMD_ADD && r_mode == MODE_LIST) begin
                            o_op.kind   = OP_APPEND;
                            n_committed = 1'b1;
                            n_pos       = POS_HIGH;
                        end else begin
                            n_rejected = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            o_op.start = start;

            // The last byte reports and closes the message.
            if (i_last_byte) begin
                o_op.last   = 1'b1;
                o_op.status = n_committed;
                n_pos       = POS_CMD;
                n_committed = 1'b0;
                n_rejected  = 1'b0;
            end
        end
    end

    // Message state moves only with an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_CMD;
            r_cmd       <= '0;
            r_bright    <= '0;
            r_high      <= '0;
            r_committed <= 1'b0;
            r_rejected  <= 1'b0;
            r_mode      <= MODE_OFF;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_cmd       <= n_cmd;
            r_bright    <= n_bright;
            r_high      <= n_high;
            r_committed <= n_committed;
            r_rejected  <= n_rejected;
            r_mode      <= n_mode;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lccp_queue.sv
// Short queue of operations between the parser and the executor.
`default_nettype none

module lccp_queue
    import lccp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_op_entry  i_entry,
    input  wire logic       i_pop,
    output t_op_entry       o_head,
    output logic            o_not_empty,
    output logic            o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op_entry         r_slot [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_head      = r_slot[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == CW'(QUEUE_DEPTH));

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/lccp_back.sv
// Back end: executes operations on mode, brightness and the color table.
`default_nettype none

module lccp_back
    import lccp_pkg::*;
#(
    parameter int MAX_COLORS = DEF_MAX_COLORS,
    parameter int CW         = $clog2(MAX_COLORS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_op_entry     i_op,
    input  wire logic          i_op_valid,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_status,
    output logic               o_overflowed,
    output logic [15:0]        o_color_value,
    output logic [CW-1:0]      o_color_count,
    output logic [1:0]         o_current_mode,
    output logic [7:0]         o_current_brightness
);

    localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    logic [15:0]    r_table [MAX_COLORS];
    logic [15:0]    r_rdata;

    logic [1:0]     r_mode, n_mode;
    logic [7:0]     r_bright, n_bright;
    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;

    logic           r_out_valid;
    logic           r_out_status;
    logic           r_out_ovf;
    logic           r_out_hit;
    logic [CW-1:0]  r_out_count;
    logic [1:0]     r_out_mode;
    logic [7:0]     r_out_bright;

    logic           has_result;
    logic           do_read;
    logic           read_hit;
    logic           msg_ovf;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [CW-1:0]  fill;

    // An operation leaves the queue unless its result would overrun the output.
    assign has_result = (i_op.kind == OP_READ) || i_op.last;
    assign o_pop      = i_op_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign do_read    = o_pop && (i_op.kind == OP_READ);
    assign read_hit   = (9'(i_op.index) < 9'(r_count));

    // State update for the operation at the head of the queue.
    always_comb begin
        n_mode   = r_mode;
        n_bright = r_bright;
        n_count  = r_count;
        msg_ovf  = i_op.start ? 1'b0 : r_ovf;
        wr_en    = 1'b0;
        fill     = (i_op.kind == OP_SET) ? '0 : r_count;
        wr_addr  = fill[AW-1:0];

        unique case (i_op.kind) inside
            OP_CLEAR: begin
                n_mode   = MODE_OFF;
                n_bright = '0;
                n_count  = '0;
            end
            OP_SET, OP_APPEND: begin
                if (i_op.kind == OP_SET) begin
                    n_mode   = i_op.mode;
                    n_bright = i_op.brightness;
                end
                if (fill < CW'(MAX_COLORS)) begin
                    wr_en   = o_pop;
                    n_count = fill + 1'b1;
                end else begin
                    n_count = fill;
                    msg_ovf = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_ovf = i_op.last ? 1'b0 : msg_ovf;
    end

    // Color table with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= i_op.color;
        end
        if (do_read) begin
            r_rdata <= r_table[i_op.index[AW-1:0]];
        end
    end

    // Stored lighting state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_bright <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (o_pop) begin
            r_mode   <= n_mode;
            r_bright <= n_bright;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
        end
    end

    // Output register: loads a result, holds it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && has_result) begin
            r_out_status <= (i_op.kind == OP_READ) ? 1'b1 : i_op.status;
            r_out_ovf    <= (i_op.kind == OP_READ) ? 1'b0 : msg_ovf;
            r_out_hit    <= (i_op.kind == OP_READ) && read_hit;
            r_out_count  <= n_count;
            r_out_mode   <= n_mode;
            r_out_bright <= n_bright;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_overflowed         = r_out_ovf;
    assign o_color_value        = r_out_hit ? r_rdata : 16'd0;
    assign o_color_count        = r_out_count;
    assign o_current_mode       = r_out_mode;
    assign o_current_brightness = r_out_bright;

endmodule

`default_nettype wire
